FILE: rtl/lru_frame_allocator_defines.svh
// assertion macros for the lru frame allocator
`ifndef LRU_FRAME_ALLOCATOR_DEFINES_SVH
`define LRU_FRAME_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every clock edge out of reset
`define LFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru_frame_allocator: same-cycle check failed");

// next-cycle implication
`define LFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru_frame_allocator: next-cycle check failed");

`else

`define LFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/lfa_pkg.sv
`default_nettype none

package lfa_pkg;

  localparam int FRAME_COUNT = 16;
  localparam int FRAME_W     = $clog2(FRAME_COUNT);
  localparam int FILL_W      = $clog2(FRAME_COUNT + 1);
  localparam int PROC_BITS   = 8;
  localparam int PAGE_BITS   = 10;

  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [FILL_W-1:0]    fill_t;
  typedef logic [PROC_BITS-1:0] proc_t;
  typedef logic [PAGE_BITS-1:0] page_t;

  localparam frame_t LAST_POS   = FRAME_W'(FRAME_COUNT - 1);
  localparam fill_t  FILL_FULL  = FILL_W'(FRAME_COUNT);

  localparam logic CMD_TOUCH = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  // recency memory port: position-addressed, holds frame numbers
  typedef struct packed {
    logic   re;
    frame_t raddr;
    logic   we;
    frame_t waddr;
    frame_t wdata;
  } ord_req_t;

  // owner memory port: frame-addressed, holds process id and page
  typedef struct packed {
    logic   re;
    frame_t raddr;
    logic   we;
    frame_t waddr;
    proc_t  wproc;
    page_t  wpage;
  } own_req_t;

endpackage

`default_nettype wire

FILE: rtl/lru_frame_allocator.sv
// LRU frame allocator for 16 physical frames. Raise start with a command while busy is low;
// the command is taken at that edge and busy stays high until the result has been shown.
// The result appears for exactly one cycle with out_valid high and cannot be stalled, so the
// receiver must capture it on that cycle. A touch walks the order memory from the front
// until it meets the frame; a load into a free frame does the same, and a load that
// evicts first reads the least recent frame and its owner. The walk moves through the
// order memory one position per cycle and ends where it meets the frame or at the last
// position. Since frames are never released, the lowest free frame is simply the fill
// count. No clearing pass runs after reset: the order memory keeps a valid bit per entry
// instead.
`default_nettype none

`include "lru_frame_allocator_defines.svh"

module lru_frame_allocator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // command transaction
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic                             in_cmd,
  input  wire logic [lfa_pkg::FRAME_W-1:0]      in_frame_in,
  input  wire logic [lfa_pkg::PROC_BITS-1:0]    in_proc_id,
  input  wire logic [lfa_pkg::PAGE_BITS-1:0]    in_page_num,
  // result transaction
  output      logic                             out_valid,
  output      logic [lfa_pkg::FRAME_W-1:0]      out_frame_out,
  output      logic                             out_evicted,
  output      logic [lfa_pkg::PROC_BITS-1:0]    out_victim_proc,
  output      logic [lfa_pkg::PAGE_BITS-1:0]    out_victim_page
);

  // one-hot sequencer
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,   // waiting for a command
    ST_VICT = 5'b00010,   // least recent position read in flight
    ST_OWN  = 5'b00100,   // victim owner read in flight
    ST_SCAN = 5'b01000,   // recency walk, one position per cycle
    ST_DONE = 5'b10000    // result strobe
  } state_t;

  state_t            state_r, state_nxt;
  lfa_pkg::fill_t    fill_r, fill_nxt;       // frames in use, lowest free frame
  lfa_pkg::frame_t   pos_r, pos_nxt;         // walk position
  lfa_pkg::frame_t   frame_r, frame_nxt;     // frame being made most recent
  lfa_pkg::frame_t   carry_r, carry_nxt;     // value shifted into current position
  lfa_pkg::proc_t    pid_r, pid_nxt;
  lfa_pkg::page_t    page_r, page_nxt;
  logic              evict_r, evict_nxt;
  lfa_pkg::proc_t    vproc_r, vproc_nxt;
  lfa_pkg::page_t    vpage_r, vpage_nxt;

  lfa_pkg::ord_req_t ord_req;
  lfa_pkg::frame_t   ord_rd;
  lfa_pkg::own_req_t own_req;
  lfa_pkg::proc_t    own_rd_proc;
  lfa_pkg::page_t    own_rd_page;

  logic              accept;
  logic              scan_stop;
  logic              touch_ok;

  lfa_order_mem u_order (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ord_req),
    .rd_data (ord_rd)
  );

  lfa_owner_mem u_owner (
    .clk     (clk),
    .req     (own_req),
    .rd_proc (own_rd_proc),
    .rd_page (own_rd_page)
  );

  assign accept    = start && !busy;
  // an out-of-range touch leaves the order alone
  assign touch_ok  = (int'(in_frame_in) < lfa_pkg::FRAME_COUNT);
  // walk ends where the frame was found, or at the last position
  assign scan_stop = (ord_rd == frame_r) || (pos_r == lfa_pkg::LAST_POS);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    frame_nxt = frame_r;
    carry_nxt = carry_r;
    pid_nxt   = pid_r;
    page_nxt  = page_r;
    evict_nxt = evict_r;
    vproc_nxt = vproc_r;
    vpage_nxt = vpage_r;

    ord_req   = '0;
    own_req   = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pid_nxt   = in_proc_id;
          page_nxt  = in_page_num;
          evict_nxt = 1'b0;
          vproc_nxt = '0;
          vpage_nxt = '0;
          pos_nxt   = '0;
          if (in_cmd == lfa_pkg::CMD_TOUCH) begin
            frame_nxt = in_frame_in;
            carry_nxt = in_frame_in;
            if (touch_ok) begin
              ord_req.re    = 1'b1;
              ord_req.raddr = '0;
              state_nxt     = ST_SCAN;
            end else begin
              state_nxt     = ST_DONE;
            end
          end else if (fill_r != lfa_pkg::FILL_FULL) begin
            // free frame: take it and record the owner now
            frame_nxt     = fill_r[lfa_pkg::FRAME_W-1:0];
            carry_nxt     = fill_r[lfa_pkg::FRAME_W-1:0];
            fill_nxt      = fill_r + 1'b1;
            own_req.we    = 1'b1;
            own_req.waddr = fill_r[lfa_pkg::FRAME_W-1:0];
            own_req.wproc = in_proc_id;
            own_req.wpage = in_page_num;
            ord_req.re    = 1'b1;
            ord_req.raddr = '0;
            state_nxt     = ST_SCAN;
          end else begin
            // all frames used: fetch the least recent frame
            ord_req.re    = 1'b1;
            ord_req.raddr = lfa_pkg::LAST_POS;
            state_nxt     = ST_VICT;
          end
        end
      end

      ST_VICT: begin
        frame_nxt     = ord_rd;
        carry_nxt     = ord_rd;
        evict_nxt     = 1'b1;
        own_req.re    = 1'b1;
        own_req.raddr = ord_rd;
        state_nxt     = ST_OWN;
      end

      ST_OWN: begin
        // read data is the old owner; overwrite in the same cycle
        vproc_nxt     = own_rd_proc;
        vpage_nxt     = own_rd_page;
        own_req.we    = 1'b1;
        own_req.waddr = frame_r;
        own_req.wproc = pid_r;
        own_req.wpage = page_r;
        ord_req.re    = 1'b1;
        ord_req.raddr = '0;
        state_nxt     = ST_SCAN;
      end

      ST_SCAN: begin
        // shift one position down; next read never hits the written entry
        ord_req.we    = 1'b1;
        ord_req.waddr = pos_r;
        ord_req.wdata = carry_r;
        carry_nxt     = ord_rd;
        if (scan_stop) begin
          state_nxt     = ST_DONE;
        end else begin
          ord_req.re    = 1'b1;
          ord_req.raddr = pos_r + 1'b1;
          pos_nxt       = pos_r + 1'b1;
        end
      end

      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    frame_r <= frame_nxt;
    carry_r <= carry_nxt;
    pid_r   <= pid_nxt;
    page_r  <= page_nxt;
    evict_r <= evict_nxt;
    vproc_r <= vproc_nxt;
    vpage_r <= vpage_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_DONE);
  assign out_frame_out   = frame_r;
  assign out_evicted     = evict_r;
  assign out_victim_proc = vproc_r;
  assign out_victim_page = vpage_r;

  // fill count never passes the frame count
  `LFA_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= lfa_pkg::FILL_FULL)
  // an accepted transaction makes the block busy
  `LFA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  // an eviction happens only with every frame in use
  `LFA_ASSERT_NOW(a_evict_full, clk, rst_n, out_valid && out_evicted,
                  fill_r == lfa_pkg::FILL_FULL)
  // result strobe lasts one cycle
  `LFA_ASSERT_NEXT(a_one_strobe, clk, rst_n, out_valid, !out_valid)
  // no eviction reports no victim
  `LFA_ASSERT_NOW(a_no_victim, clk, rst_n, out_valid && !out_evicted,
                  out_victim_proc == '0 && out_victim_page == '0)

endmodule

`default_nettype wire

FILE: rtl/lfa_order_mem.sv
`default_nettype none

// recency order memory, registered read
// an entry never written reads as its own position (reset order)
module lfa_order_mem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lfa_pkg::ord_req_t req,
  output lfa_pkg::frame_t        rd_data
);

  lfa_pkg::frame_t                     mem [lfa_pkg::FRAME_COUNT];
  logic [lfa_pkg::FRAME_COUNT-1:0]     vld_r;
  lfa_pkg::frame_t                     rdata_r;
  lfa_pkg::frame_t                     raddr_r;
  logic                                rvld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
      raddr_r <= req.raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rvld_r <= vld_r[req.raddr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : raddr_r;

endmodule

`default_nettype wire

FILE: rtl/lfa_owner_mem.sv
`default_nettype none

// owner memory, registered read, no reset contents
module lfa_owner_mem (
  input  wire logic              clk,
  input  wire lfa_pkg::own_req_t req,
  output lfa_pkg::proc_t         rd_proc,
  output lfa_pkg::page_t         rd_page
);

  lfa_pkg::proc_t mem_proc [lfa_pkg::FRAME_COUNT];
  lfa_pkg::page_t mem_page [lfa_pkg::FRAME_COUNT];
  lfa_pkg::proc_t rproc_r;
  lfa_pkg::page_t rpage_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_proc[req.waddr] <= req.wproc;
      mem_page[req.waddr] <= req.wpage;
    end
    if (req.re) begin
      rproc_r <= mem_proc[req.raddr];
      rpage_r <= mem_page[req.raddr];
    end
  end

  assign rd_proc = rproc_r;
  assign rd_page = rpage_r;

endmodule

`default_nettype wire
